// ===== src/m3inv_pkg.sv =====
// Shared widths, types and constants for the 3x3 matrix inverse pipeline.
package m3inv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int COF_W     = 2 * ELEM_W;
    localparam int DET_W     = 3 * ELEM_W + 1;
    localparam int MAG_W     = 3 * ELEM_W;
    localparam int NUM_W     = COF_W + 2 * FRAC_BITS;
    localparam int QB        = ELEM_W + 1;
    localparam int WIDE_W    = MAG_W + QB;

    localparam int COF_LAT   = 2;
    localparam int DET_LAT   = 3;
    localparam int LANE_LAT  = QB + 1;
    localparam int PIPE_LAT  = COF_LAT + DET_LAT + 1 + LANE_LAT + 1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PROD_W:0]   plo_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [NUM_W-1:0]         num_t;
    typedef logic [QB-1:0]            quo_t;
    typedef logic [WIDE_W-1:0]        wide_t;

    localparam quo_t POS_LIM = quo_t'(32'h7FFF_FFFF);
    localparam quo_t NEG_LIM = quo_t'(32'h8000_0000);
    localparam elem_t POS_SAT = elem_t'(32'h7FFF_FFFF);
    localparam elem_t NEG_SAT = elem_t'(32'h8000_0000);

    typedef struct packed {
        quo_t quo;
        logic big;
        logic neg;
    } lane_res_t;

endpackage

// ===== src/m3inv_cofactor.sv =====
// Cofactor stages: element products, then their differences.
module m3inv_cofactor (
    input  logic            clk,
    input  logic            en,
    input  m3inv_pkg::elem_t elem [3][3],
    output m3inv_pkg::cof_t  cof [3][3],
    output m3inv_pkg::elem_t row0 [3]
);
    import m3inv_pkg::*;

    prod_t pp_reg [3][3];
    prod_t qq_reg [3][3];
    cof_t  cof_reg [3][3];
    elem_t row0_s1_reg [3];
    elem_t row0_s2_reg [3];

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;
            localparam int R1 = (r + 1) % 3;
            localparam int R2 = (r + 2) % 3;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg[r][c]  <= prod_t'(elem[C1][R1]) * prod_t'(elem[C2][R2]);
                    qq_reg[r][c]  <= prod_t'(elem[C1][R2]) * prod_t'(elem[C2][R1]);
                    // true difference fits in 64 bits
                    cof_reg[r][c] <= pp_reg[r][c] - qq_reg[r][c];
                end
            end
            assign cof[r][c] = cof_reg[r][c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                row0_s1_reg[c] <= elem[0][c];
                row0_s2_reg[c] <= row0_s1_reg[c];
            end
        end
    end

    assign row0 = row0_s2_reg;

endmodule

// ===== src/m3inv_det.sv =====
// Determinant stages: split products, term assembly, final sum; cofactors ride along.
module m3inv_det (
    input  logic            clk,
    input  logic            en,
    input  m3inv_pkg::elem_t row0 [3],
    input  m3inv_pkg::cof_t  cof_in [3][3],
    output m3inv_pkg::cof_t  cof_out [3][3],
    output m3inv_pkg::det_t  det
);
    import m3inv_pkg::*;

    plo_t  plo_reg [3];
    prod_t phi_reg [3];
    det_t  term_reg [3];
    det_t  det_reg;
    cof_t  cof_d1_reg [3][3];
    cof_t  cof_d2_reg [3][3];
    cof_t  cof_d3_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                // low half unsigned, high half signed
                plo_reg[c]  <= plo_t'(row0[c]) *
                               plo_t'($signed({1'b0, cof_in[c][0][ELEM_W-1:0]}));
                phi_reg[c]  <= prod_t'(row0[c]) *
                               prod_t'($signed(cof_in[c][0][COF_W-1:ELEM_W]));
                term_reg[c] <= (det_t'(phi_reg[c]) <<< ELEM_W) + det_t'(plo_reg[c]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    cof_d1_reg[r][c] <= cof_in[r][c];
                    cof_d2_reg[r][c] <= cof_d1_reg[r][c];
                    cof_d3_reg[r][c] <= cof_d2_reg[r][c];
                end
            end
        end
    end

    assign cof_out = cof_d3_reg;
    assign det     = det_reg;

endmodule

// ===== src/m3inv_div_lane.sv =====
// One divider lane: range check, then one restoring quotient bit per stage.
module m3inv_div_lane (
    input  logic                  clk,
    input  logic                  en,
    input  m3inv_pkg::num_t       num,
    input  m3inv_pkg::mag_t       dmag,
    input  logic                  neg,
    output m3inv_pkg::lane_res_t  res
);
    import m3inv_pkg::*;

    num_t rem_reg [QB+1];
    mag_t d_reg   [QB+1];
    quo_t q_reg   [QB+1];
    logic big_reg [QB+1];
    logic neg_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            d_reg[0]   <= dmag;
            q_reg[0]   <= '0;
            big_reg[0] <= wide_t'(num) >= (wide_t'(dmag) << QB);
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        localparam int BIT = QB - k;
        wide_t rem_wide;
        wide_t trial;
        logic  ge;
        assign rem_wide = wide_t'(rem_reg[k-1]);
        assign trial    = wide_t'(d_reg[k-1]) << BIT;
        assign ge       = rem_wide >= trial;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? num_t'(rem_wide - trial) : rem_reg[k-1];
                q_reg[k]   <= ge ? (q_reg[k-1] | (quo_t'(1) << BIT)) : q_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                big_reg[k] <= big_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign res.quo = q_reg[QB];
    assign res.big = big_reg[QB];
    assign res.neg = neg_reg[QB];

endmodule

// ===== src/matrix3_inverse.sv =====
// Throughput: one matrix per cycle while no result is held; every stage is a single register step.
// Depth is set by the nine divider lanes, one quotient bit per stage (33 bits plus a range check).
// The whole pipeline holds while a finished result waits at the output and out_ready is low.
// Reset (rst_n, asynchronous, active low) clears only the valid bits; data registers keep values.
module matrix3_inverse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  m3inv_pkg::elem_t in_r0c0,
    input  m3inv_pkg::elem_t in_r1c0,
    input  m3inv_pkg::elem_t in_r2c0,
    input  m3inv_pkg::elem_t in_r0c1,
    input  m3inv_pkg::elem_t in_r1c1,
    input  m3inv_pkg::elem_t in_r2c1,
    input  m3inv_pkg::elem_t in_r0c2,
    input  m3inv_pkg::elem_t in_r1c2,
    input  m3inv_pkg::elem_t in_r2c2,
    output logic             out_valid,
    input  logic             out_ready,
    output m3inv_pkg::elem_t inv_r0c0,
    output m3inv_pkg::elem_t inv_r1c0,
    output m3inv_pkg::elem_t inv_r2c0,
    output m3inv_pkg::elem_t inv_r0c1,
    output m3inv_pkg::elem_t inv_r1c1,
    output m3inv_pkg::elem_t inv_r2c1,
    output m3inv_pkg::elem_t inv_r0c2,
    output m3inv_pkg::elem_t inv_r1c2,
    output m3inv_pkg::elem_t inv_r2c2,
    output logic             singular,
    output logic             overflow
);
    import m3inv_pkg::*;

    logic      en;
    elem_t     elem [3][3];
    cof_t      cof_s2 [3][3];
    elem_t     row0_s2 [3];
    cof_t      cof_s5 [3][3];
    det_t      det_s5;
    det_t      det_abs;

    // prep stage registers
    num_t      num_reg  [3][3];
    logic      neg_reg  [3][3];
    mag_t      dmag_reg;
    logic      zero_reg;

    lane_res_t lane_res [3][3];
    logic      sing_pipe_reg [LANE_LAT];
    logic      vld_reg [PIPE_LAT];

    elem_t     inv_next [3][3];
    logic      sat_next [3][3];
    logic      ovf_next;
    elem_t     inv_reg  [3][3];
    logic      sing_reg;
    logic      ovf_reg;

    // advance everything unless a result is held at the output
    assign en       = !vld_reg[PIPE_LAT-1] || out_ready;
    assign in_ready = en;

    assign elem[0][0] = in_r0c0;
    assign elem[1][0] = in_r1c0;
    assign elem[2][0] = in_r2c0;
    assign elem[0][1] = in_r0c1;
    assign elem[1][1] = in_r1c1;
    assign elem[2][1] = in_r2c1;
    assign elem[0][2] = in_r0c2;
    assign elem[1][2] = in_r1c2;
    assign elem[2][2] = in_r2c2;

    m3inv_cofactor u_cofactor (
        .clk  (clk),
        .en   (en),
        .elem (elem),
        .cof  (cof_s2),
        .row0 (row0_s2)
    );

    m3inv_det u_det (
        .clk     (clk),
        .en      (en),
        .row0    (row0_s2),
        .cof_in  (cof_s2),
        .cof_out (cof_s5),
        .det     (det_s5)
    );

    // Prep: magnitudes, numerators shifted left by 2F bits, quotient sign, singular test.
    assign det_abs = det_s5[DET_W-1] ? -det_s5 : det_s5;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    num_reg[r][c] <= {(cof_s5[r][c][COF_W-1] ? -cof_s5[r][c] : cof_s5[r][c]),
                                      {(2 * FRAC_BITS){1'b0}}};
                    neg_reg[r][c] <= cof_s5[r][c][COF_W-1] ^ det_s5[DET_W-1];
                end
            end
            dmag_reg <= det_abs[MAG_W-1:0];
            zero_reg <= (det_s5 == '0);
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_lane_row
        for (genvar c = 0; c < 3; c++)
        begin : g_lane_col
            m3inv_div_lane u_lane (
                .clk  (clk),
                .en   (en),
                .num  (num_reg[r][c]),
                .dmag (dmag_reg),
                .neg  (neg_reg[r][c]),
                .res  (lane_res[r][c])
            );
        end
    end

    // carry the singular flag alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_pipe_reg[0] <= zero_reg;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                sing_pipe_reg[i] <= sing_pipe_reg[i-1];
            end
        end
    end

    // Final: apply sign, saturate, or force zeros for a singular matrix.
    always_comb
    begin
        ovf_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (lane_res[r][c].neg)
                begin
                    sat_next[r][c] = lane_res[r][c].big || (lane_res[r][c].quo > NEG_LIM);
                    inv_next[r][c] = sat_next[r][c] ? NEG_SAT
                                   : elem_t'(quo_t'(0) - lane_res[r][c].quo);
                end
                else
                begin
                    sat_next[r][c] = lane_res[r][c].big || (lane_res[r][c].quo > POS_LIM);
                    inv_next[r][c] = sat_next[r][c] ? POS_SAT
                                   : elem_t'(lane_res[r][c].quo);
                end
                if (sing_pipe_reg[LANE_LAT-1])
                begin
                    sat_next[r][c] = 1'b0;
                    inv_next[r][c] = '0;
                end
                ovf_next = ovf_next | sat_next[r][c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg  <= inv_next;
            sing_reg <= sing_pipe_reg[LANE_LAT-1];
            ovf_reg  <= ovf_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[PIPE_LAT-1];
    assign inv_r0c0  = inv_reg[0][0];
    assign inv_r1c0  = inv_reg[1][0];
    assign inv_r2c0  = inv_reg[2][0];
    assign inv_r0c1  = inv_reg[0][1];
    assign inv_r1c1  = inv_reg[1][1];
    assign inv_r2c1  = inv_reg[2][1];
    assign inv_r0c2  = inv_reg[0][2];
    assign inv_r1c2  = inv_reg[1][2];
    assign inv_r2c2  = inv_reg[2][2];
    assign singular  = sing_reg;
    assign overflow  = ovf_reg;

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> inv_r0c0 == '0 && inv_r1c1 == '0 && inv_r2c2 == '0
                                   && inv_r1c0 == '0 && inv_r0c2 == '0)
        else $error("singular result carries nonzero elements");

    a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !overflow)
        else $error("singular result flags overflow");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            inv_r0c0 == POS_SAT || inv_r0c0 == NEG_SAT || inv_r1c0 == POS_SAT ||
            inv_r1c0 == NEG_SAT || inv_r2c0 == POS_SAT || inv_r2c0 == NEG_SAT ||
            inv_r0c1 == POS_SAT || inv_r0c1 == NEG_SAT || inv_r1c1 == POS_SAT ||
            inv_r1c1 == NEG_SAT || inv_r2c1 == POS_SAT || inv_r2c1 == NEG_SAT ||
            inv_r0c2 == POS_SAT || inv_r0c2 == NEG_SAT || inv_r1c2 == POS_SAT ||
            inv_r1c2 == NEG_SAT || inv_r2c2 == POS_SAT || inv_r2c2 == NEG_SAT)
        else $error("overflow without a saturated element");

endmodule
